[hdl/wildcard_multi_pattern_matcher_defines.svh]
// ----------------------------------------------------------------------------
// Wildcard multi-pattern matcher: assertion macros
// Shared concurrent assertion forms used by the matcher RTL.
// ----------------------------------------------------------------------------
`ifndef WILDCARD_MULTI_PATTERN_MATCHER_DEFINES_SVH
`define WILDCARD_MULTI_PATTERN_MATCHER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define WMPM_ASSERT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define WMPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/wmpm_pkg.sv]
// ----------------------------------------------------------------------------
// Wildcard multi-pattern matcher package
// Shared types and fixed constants of the matcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wmpm_pkg;

   localparam int SYM_W      = 8;
   localparam int PNUM_W     = 7;
   localparam int RESULT_CAP = 16;
   localparam int CAP_W      = 5;
   localparam logic [SYM_W-1:0] SKIP_RESET = 8'd63;

   typedef struct packed {
      logic             func;
      logic [SYM_W-1:0] symbol;
      logic             last;
      logic             first;
   } item_type;

   // Classified command handed from the front end to the engine.
   typedef struct packed {
      logic             valid;
      logic             is_text;
      logic             restart;
      logic             close;
      logic [SYM_W-1:0] symbol;
   } cmd_type;

endpackage

[hdl/wmpm_fifo.sv]
// ----------------------------------------------------------------------------
// Matcher queue
// Small synchronous first-in first-out queue built from flip-flops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wmpm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == (AW+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

[hdl/wmpm_front.sv]
// ----------------------------------------------------------------------------
// Matcher front end
// Accepts input beats into a short queue and classifies the oldest one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wmpm_front
   import wmpm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  logic             req_func,
   input  logic [SYM_W-1:0] req_symbol,
   input  logic             req_last,
   input  logic             req_first,
   output cmd_type          cmd,
   input  logic             cmd_pop
);

   item_type in_item;
   item_type head;
   logic     q_empty;

   assign in_item = '{func: req_func, symbol: req_symbol, last: req_last, first: req_first};

   wmpm_fifo #(
      .WIDTH ($bits(item_type)),
      .DEPTH (4)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .wr_data (in_item),
      .full    (req_full),
      .pop     (cmd_pop),
      .rd_data (head),
      .empty   (q_empty)
   );

   // The restart flag only means something on text beats, the close flag only
   // on pattern beats.
   always_comb begin
      cmd.valid   = !q_empty;
      cmd.is_text = head.func;
      cmd.restart = head.func && head.first;
      cmd.close   = !head.func && head.last;
      cmd.symbol  = head.symbol;
   end

endmodule

[hdl/wmpm_engine.sv]
// ----------------------------------------------------------------------------
// Matcher engine
// Builds the trie, rebuilds suffix links level by level, scans text and
// walks the suffix chain to report matches.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "wildcard_multi_pattern_matcher_defines.svh"

module wmpm_engine
   import wmpm_pkg::*;
#(
   parameter int MAX_NODES    = 256,
   parameter int MAX_PATTERNS = 64,
   parameter int MAX_DEPTH    = 16,
   parameter int POS_BITS     = 20
) (
   input  logic                                clock,
   input  logic                                reset,
   input  cmd_type                             cmd,
   output logic                                cmd_pop,
   input  logic                                csr_we,
   input  logic [SYM_W-1:0]                    csr_wdata,
   output logic                                out_push,
   output logic [POS_BITS+1+PNUM_W+1-1:0]      out_data,
   input  logic                                out_full
);

   localparam int NODE_W  = $clog2(MAX_NODES);
   localparam int CNT_W   = NODE_W + 1;
   localparam int PIDX_W  = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
   localparam int PCNT_W  = $clog2(MAX_PATTERNS + 1);
   localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
   localparam int CT_AW   = NODE_W + SYM_W;
   localparam int START_W = POS_BITS + 1;
   localparam int PEND_W  = START_W + PNUM_W;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_MV_A = 4'd1;
   localparam logic [3:0] S_MV_B = 4'd2;
   localparam logic [3:0] S_MV_C = 4'd3;
   localparam logic [3:0] S_MV_L = 4'd4;
   localparam logic [3:0] S_MV_M = 4'd5;
   localparam logic [3:0] S_BD_A = 4'd6;
   localparam logic [3:0] S_BD_B = 4'd7;
   localparam logic [3:0] S_BD_P = 4'd8;
   localparam logic [3:0] S_BD_Q = 4'd9;
   localparam logic [3:0] S_WK_A = 4'd10;
   localparam logic [3:0] S_WK_B = 4'd11;

   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_BUILD = 2'd1;
   localparam logic [1:0] MODE_SCAN  = 2'd2;

   // Storage
   logic [NODE_W-1:0]  child_mem  [MAX_NODES*256];
   logic [NODE_W-1:0]  parent_mem [MAX_NODES];
   logic [SYM_W-1:0]   label_mem  [MAX_NODES];
   logic [DEPTH_W-1:0] depth_mem  [MAX_NODES];
   logic [PIDX_W-1:0]  pat_mem    [MAX_NODES];
   logic [NODE_W-1:0]  link_mem   [MAX_NODES];

   logic [NODE_W-1:0]  ct_rd_ff;
   logic [NODE_W-1:0]  par_rd_ff;
   logic [SYM_W-1:0]   lab_rd_ff;
   logic [DEPTH_W-1:0] dep_rd_ff;
   logic [PIDX_W-1:0]  pat_rd_ff;
   logic [NODE_W-1:0]  link_rd_ff;

   logic [MAX_NODES-1:0] term_ff;

   // Control registers
   logic [3:0]         state_ff, state_in;
   logic [1:0]         mode_ff, mode_in;
   logic [NODE_W-1:0]  mv_node_ff, mv_node_in;
   logic [SYM_W-1:0]   mv_sym_ff, mv_sym_in;
   logic               try_ff, try_in;
   logic [NODE_W-1:0]  ins_cur_ff, ins_cur_in;
   logic [DEPTH_W-1:0] ld_depth_ff, ld_depth_in;
   logic               dropped_ff, dropped_in;
   logic               ld_last_ff, ld_last_in;
   logic [CNT_W-1:0]   node_cnt_ff, node_cnt_in;
   logic [PCNT_W-1:0]  pat_cnt_ff, pat_cnt_in;
   logic [NODE_W-1:0]  scan_cur_ff, scan_cur_in;
   logic [POS_BITS-1:0] pos_ff, pos_in;
   logic               dirty_ff, dirty_in;
   logic [SYM_W-1:0]   skip_ff, skip_in;
   logic [NODE_W-1:0]  bi_ff, bi_in;
   logic [DEPTH_W-1:0] lvl_ff, lvl_in;
   logic [NODE_W-1:0]  wk_node_ff, wk_node_in;
   logic [CAP_W-1:0]   res_cnt_ff, res_cnt_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [PEND_W-1:0]  pend_ff, pend_in;

   // Memory control
   logic               ct_re, nd_re, ct_we, nd_we, pm_we, lk_we;
   logic [CT_AW-1:0]   ct_raddr, ct_waddr;
   logic [NODE_W-1:0]  ct_wdata, nd_raddr, nd_waddr, pm_waddr, lk_waddr, lk_wdata;
   logic [NODE_W-1:0]  nd_wpar;
   logic [SYM_W-1:0]   nd_wlab;
   logic [DEPTH_W-1:0] nd_wdep;
   logic [PIDX_W-1:0]  pm_wdata;
   logic               term_set, term_clr;
   logic [NODE_W-1:0]  term_set_idx, term_clr_idx;

   logic [SYM_W-1:0]   cur_sym;
   logic               found;
   logic               bi_last;
   logic               fin, adv;
   logic [NODE_W-1:0]  fin_node;
   logic               ld_ok;
   logic [NODE_W-1:0]  ld_cur;
   logic               hit;
   logic [POS_BITS-1:0] len_ext;
   logic [START_W-1:0] start_val;
   logic [PIDX_W:0]    pnum_full;
   logic [PEND_W-1:0]  new_res;
   logic [NODE_W-1:0]  scan_base;
   logic [POS_BITS-1:0] pos_base;

   assign cur_sym = try_ff ? skip_ff : mv_sym_ff;
   // A child entry is trusted only if the node it names really hangs below
   // this node under this label; this avoids clearing the child table.
   assign found   = (ct_rd_ff != '0) && ({1'b0, ct_rd_ff} < node_cnt_ff)
                    && (par_rd_ff == mv_node_ff) && (lab_rd_ff == cur_sym);
   assign bi_last = (({1'b0, bi_ff} + CNT_W'(1)) == node_cnt_ff);

   assign hit       = term_ff[wk_node_ff] && (res_cnt_ff < CAP_W'(RESULT_CAP));
   assign len_ext   = POS_BITS'(dep_rd_ff);
   assign start_val = (pos_ff >= len_ext)
                      ? ({1'b0, pos_ff} + START_W'(1) - {1'b0, len_ext})
                      : START_W'(1);
   assign pnum_full = {1'b0, pat_rd_ff} + (PIDX_W+1)'(1);
   assign new_res   = {start_val, PNUM_W'(pnum_full)};

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      mv_node_in    = mv_node_ff;
      mv_sym_in     = mv_sym_ff;
      try_in        = try_ff;
      ins_cur_in    = ins_cur_ff;
      ld_depth_in   = ld_depth_ff;
      dropped_in    = dropped_ff;
      ld_last_in    = ld_last_ff;
      node_cnt_in   = node_cnt_ff;
      pat_cnt_in    = pat_cnt_ff;
      scan_cur_in   = scan_cur_ff;
      pos_in        = pos_ff;
      dirty_in      = dirty_ff;
      skip_in       = skip_ff;
      bi_in         = bi_ff;
      lvl_in        = lvl_ff;
      wk_node_in    = wk_node_ff;
      res_cnt_in    = res_cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;

      cmd_pop  = 1'b0;
      out_push = 1'b0;
      out_data = {pend_ff, 1'b0};
      ct_re    = 1'b0;
      ct_raddr = {mv_node_ff, cur_sym};
      nd_re    = 1'b0;
      nd_raddr = mv_node_ff;
      ct_we    = 1'b0;
      ct_waddr = {mv_node_ff, mv_sym_ff};
      ct_wdata = node_cnt_ff[NODE_W-1:0];
      nd_we    = 1'b0;
      nd_waddr = node_cnt_ff[NODE_W-1:0];
      nd_wpar  = mv_node_ff;
      nd_wlab  = mv_sym_ff;
      nd_wdep  = ld_depth_ff + DEPTH_W'(1);
      pm_we    = 1'b0;
      pm_waddr = ins_cur_ff;
      pm_wdata = PIDX_W'(pat_cnt_ff);
      lk_we    = 1'b0;
      lk_waddr = bi_ff;
      lk_wdata = '0;
      term_set     = 1'b0;
      term_clr     = 1'b0;
      term_set_idx = ins_cur_ff;
      term_clr_idx = node_cnt_ff[NODE_W-1:0];
      fin      = 1'b0;
      fin_node = '0;
      adv      = 1'b0;
      ld_ok    = 1'b0;
      ld_cur   = ins_cur_ff;
      scan_base = cmd.restart ? '0 : scan_cur_ff;
      pos_base  = cmd.restart ? '0 : pos_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd.valid) begin
               if (cmd.is_text) begin
                  if (dirty_ff) begin
                     if (node_cnt_ff == CNT_W'(1)) begin
                        dirty_in = 1'b0;
                     end else begin
                        lvl_in   = DEPTH_W'(1);
                        bi_in    = NODE_W'(1);
                        mode_in  = MODE_BUILD;
                        state_in = S_BD_A;
                     end
                  end else begin
                     cmd_pop    = 1'b1;
                     pos_in     = (pos_base == '1) ? pos_base : pos_base + POS_BITS'(1);
                     mv_node_in = scan_base;
                     mv_sym_in  = cmd.symbol;
                     try_in     = 1'b0;
                     mode_in    = MODE_SCAN;
                     state_in   = S_MV_A;
                  end
               end else begin
                  cmd_pop  = 1'b1;
                  dirty_in = 1'b1;
                  if (dropped_ff || (pat_cnt_ff >= PCNT_W'(MAX_PATTERNS))
                      || (ld_depth_ff >= DEPTH_W'(MAX_DEPTH))) begin
                     if (cmd.close) begin
                        ins_cur_in  = '0;
                        ld_depth_in = '0;
                        dropped_in  = 1'b0;
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end else begin
                     mv_node_in = ins_cur_ff;
                     mv_sym_in  = cmd.symbol;
                     try_in     = 1'b0;
                     ld_last_in = cmd.close;
                     mode_in    = MODE_LOAD;
                     state_in   = S_MV_A;
                  end
               end
            end
         end
         S_MV_A: begin
            ct_re    = 1'b1;
            state_in = S_MV_B;
         end
         S_MV_B: begin
            nd_re    = 1'b1;
            nd_raddr = ct_rd_ff;
            state_in = S_MV_C;
         end
         S_MV_C: begin
            if (mode_ff == MODE_LOAD) begin
               if (found) begin
                  ld_ok  = 1'b1;
                  ld_cur = ct_rd_ff;
               end else if (node_cnt_ff < CNT_W'(MAX_NODES)) begin
                  ld_ok       = 1'b1;
                  ld_cur      = node_cnt_ff[NODE_W-1:0];
                  ct_we       = 1'b1;
                  nd_we       = 1'b1;
                  term_clr    = 1'b1;
                  node_cnt_in = node_cnt_ff + CNT_W'(1);
               end
               if (ld_last_ff) begin
                  if (ld_ok && (ld_cur != '0)) begin
                     term_set     = 1'b1;
                     term_set_idx = ld_cur;
                     pm_we        = 1'b1;
                     pm_waddr     = ld_cur;
                     pat_cnt_in   = pat_cnt_ff + PCNT_W'(1);
                  end
                  ins_cur_in  = '0;
                  ld_depth_in = '0;
                  dropped_in  = 1'b0;
               end else begin
                  ins_cur_in  = ld_ok ? ld_cur : ins_cur_ff;
                  ld_depth_in = ld_ok ? ld_depth_ff + DEPTH_W'(1) : ld_depth_ff;
                  dropped_in  = !ld_ok;
               end
               state_in = S_IDLE;
            end else begin
               if (found) begin
                  fin      = 1'b1;
                  fin_node = ct_rd_ff;
               end else if (!try_ff) begin
                  try_in   = 1'b1;
                  state_in = S_MV_A;
               end else if (mv_node_ff == '0) begin
                  fin = 1'b1;
               end else begin
                  state_in = S_MV_L;
               end
            end
         end
         S_MV_L: begin
            nd_re    = 1'b1;
            state_in = S_MV_M;
         end
         S_MV_M: begin
            mv_node_in = link_rd_ff;
            try_in     = 1'b0;
            state_in   = S_MV_A;
         end
         S_BD_A: begin
            nd_re    = 1'b1;
            nd_raddr = bi_ff;
            state_in = S_BD_B;
         end
         S_BD_B: begin
            if (dep_rd_ff == lvl_ff) begin
               if (par_rd_ff == '0) begin
                  lk_we = 1'b1;
                  adv   = 1'b1;
               end else begin
                  mv_node_in = par_rd_ff;
                  mv_sym_in  = lab_rd_ff;
                  state_in   = S_BD_P;
               end
            end else begin
               adv = 1'b1;
            end
         end
         S_BD_P: begin
            nd_re    = 1'b1;
            state_in = S_BD_Q;
         end
         S_BD_Q: begin
            mv_node_in = link_rd_ff;
            try_in     = 1'b0;
            state_in   = S_MV_A;
         end
         S_WK_A: begin
            if (wk_node_ff == '0) begin
               // The held result is the final one for this text beat.
               if (pend_valid_ff) begin
                  if (!out_full) begin
                     out_push      = 1'b1;
                     out_data      = {pend_ff, 1'b1};
                     pend_valid_in = 1'b0;
                     state_in      = S_IDLE;
                  end
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               nd_re    = 1'b1;
               nd_raddr = wk_node_ff;
               state_in = S_WK_B;
            end
         end
         S_WK_B: begin
            if (!(hit && pend_valid_ff && out_full)) begin
               if (hit) begin
                  if (pend_valid_ff) begin
                     out_push = 1'b1;
                     out_data = {pend_ff, 1'b0};
                  end
                  pend_in       = new_res;
                  pend_valid_in = 1'b1;
                  res_cnt_in    = res_cnt_ff + CAP_W'(1);
               end
               wk_node_in = link_rd_ff;
               state_in   = S_WK_A;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (fin) begin
         if (mode_ff == MODE_BUILD) begin
            lk_we    = 1'b1;
            lk_wdata = fin_node;
            adv      = 1'b1;
         end else begin
            scan_cur_in   = fin_node;
            wk_node_in    = fin_node;
            res_cnt_in    = '0;
            pend_valid_in = 1'b0;
            state_in      = S_WK_A;
         end
      end

      // Links are rebuilt one depth level at a time, so every link a fallback
      // needs is already in place.
      if (adv) begin
         if (bi_last) begin
            if (lvl_ff == DEPTH_W'(MAX_DEPTH)) begin
               dirty_in = 1'b0;
               state_in = S_IDLE;
            end else begin
               lvl_in   = lvl_ff + DEPTH_W'(1);
               bi_in    = NODE_W'(1);
               state_in = S_BD_A;
            end
         end else begin
            bi_in    = bi_ff + NODE_W'(1);
            state_in = S_BD_A;
         end
      end

      if (csr_we) begin
         skip_in  = csr_wdata;
         dirty_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         mode_ff       <= MODE_LOAD;
         try_ff        <= 1'b0;
         ins_cur_ff    <= '0;
         ld_depth_ff   <= '0;
         dropped_ff    <= 1'b0;
         ld_last_ff    <= 1'b0;
         node_cnt_ff   <= CNT_W'(1);
         pat_cnt_ff    <= '0;
         scan_cur_ff   <= '0;
         pos_ff        <= '0;
         dirty_ff      <= 1'b1;
         skip_ff       <= SKIP_RESET;
         bi_ff         <= '0;
         lvl_ff        <= '0;
         wk_node_ff    <= '0;
         res_cnt_ff    <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         try_ff        <= try_in;
         ins_cur_ff    <= ins_cur_in;
         ld_depth_ff   <= ld_depth_in;
         dropped_ff    <= dropped_in;
         ld_last_ff    <= ld_last_in;
         node_cnt_ff   <= node_cnt_in;
         pat_cnt_ff    <= pat_cnt_in;
         scan_cur_ff   <= scan_cur_in;
         pos_ff        <= pos_in;
         dirty_ff      <= dirty_in;
         skip_ff       <= skip_in;
         bi_ff         <= bi_in;
         lvl_ff        <= lvl_in;
         wk_node_ff    <= wk_node_in;
         res_cnt_ff    <= res_cnt_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mv_node_ff <= mv_node_in;
      mv_sym_ff  <= mv_sym_in;
      pend_ff    <= pend_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         term_ff <= '0;
      end else begin
         if (term_clr) begin
            term_ff[term_clr_idx] <= 1'b0;
         end
         if (term_set) begin
            term_ff[term_set_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ct_we) begin
         child_mem[ct_waddr] <= ct_wdata;
      end
      if (ct_re) begin
         ct_rd_ff <= child_mem[ct_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (nd_we) begin
         parent_mem[nd_waddr] <= nd_wpar;
         label_mem[nd_waddr]  <= nd_wlab;
         depth_mem[nd_waddr]  <= nd_wdep;
      end
      if (pm_we) begin
         pat_mem[pm_waddr] <= pm_wdata;
      end
      if (lk_we) begin
         link_mem[lk_waddr] <= lk_wdata;
      end
      if (nd_re) begin
         par_rd_ff  <= parent_mem[nd_raddr];
         lab_rd_ff  <= label_mem[nd_raddr];
         dep_rd_ff  <= depth_mem[nd_raddr];
         pat_rd_ff  <= pat_mem[nd_raddr];
         link_rd_ff <= link_mem[nd_raddr];
      end
   end

   `WMPM_ASSERT(a_push_room, clock, reset, out_push, !out_full, "result beat pushed into a full queue")
   `WMPM_ASSERT(a_result_cap, clock, reset, 1'b1, res_cnt_ff <= CAP_W'(RESULT_CAP), "result count above cap")
   `WMPM_ASSERT(a_node_bound, clock, reset, 1'b1, node_cnt_ff <= CNT_W'(MAX_NODES), "node count above store size")
   `WMPM_ASSERT_NEXT(a_scan_start, clock, reset, (state_ff == S_IDLE) && cmd_pop && cmd.is_text, state_ff == S_MV_A, "text beat did not start a move")

endmodule

[hdl/wildcard_multi_pattern_matcher.sv]
// ----------------------------------------------------------------------------
// Wildcard multi-pattern matcher
// Trie of patterns with a wildcard edge, scanned by text beats; reports up to
// RESULT_CAP patterns that end at each text symbol, deepest match first.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         push / full            func, symbol, last, first
//   rsp_      out        pop / empty            start_pos, pattern_num, last_match
//   csr_      in         we (always taken)      wdata = wildcard symbol
//
// A pattern beat does one child table read and one node read in the engine.
// A text beat looks up a child for the symbol, then for the wildcard, and
// falls back along suffix links until one is found or the root is reached;
// it then walks the suffix chain node by node. The first text beat after
// pattern loads or a wildcard change first rebuilds all suffix links: a sweep of
// all nodes per level up to MAX_DEPTH, with a move for each node at its level.
// There is no clearing pass after reset. Both sides have 4-beat queues, so
// a stalled result side stops the engine only once its queue is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wildcard_multi_pattern_matcher
   import wmpm_pkg::*;
#(
   parameter int MAX_NODES    = 256,
   parameter int MAX_PATTERNS = 64,
   parameter int MAX_DEPTH    = 16,
   parameter int POS_BITS     = 20
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic                req_func,
   input  logic [SYM_W-1:0]    req_symbol,
   input  logic                req_last,
   input  logic                req_first,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [POS_BITS:0]   rsp_start_pos,
   output logic [PNUM_W-1:0]   rsp_pattern_num,
   output logic                rsp_last_match,
   input  logic                csr_we,
   input  logic [SYM_W-1:0]    csr_wdata
);

   localparam int RES_W = POS_BITS + 1 + PNUM_W + 1;

   cmd_type          cmd;
   logic             cmd_pop;
   logic             out_push;
   logic             out_full;
   logic [RES_W-1:0] out_data;
   logic [RES_W-1:0] rsp_data;

   wmpm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_func   (req_func),
      .req_symbol (req_symbol),
      .req_last   (req_last),
      .req_first  (req_first),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   wmpm_engine #(
      .MAX_NODES    (MAX_NODES),
      .MAX_PATTERNS (MAX_PATTERNS),
      .MAX_DEPTH    (MAX_DEPTH),
      .POS_BITS     (POS_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .out_push  (out_push),
      .out_data  (out_data),
      .out_full  (out_full)
   );

   wmpm_fifo #(
      .WIDTH (RES_W),
      .DEPTH (4)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (out_push),
      .wr_data (out_data),
      .full    (out_full),
      .pop     (rsp_pop),
      .rd_data (rsp_data),
      .empty   (rsp_empty)
   );

   assign rsp_start_pos   = rsp_data[RES_W-1 -: POS_BITS+1];
   assign rsp_pattern_num = rsp_data[PNUM_W:1];
   assign rsp_last_match  = rsp_data[0];

endmodule
